/* rtl/core/range_mapping_table_defines.svh */
// assertion macros for the range mapping table checker
`ifndef RANGE_MAPPING_TABLE_DEFINES_SVH
`define RANGE_MAPPING_TABLE_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define RMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define RMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rmt_pkg.sv */
// shared sizes, field widths and codes for the range mapping table
`timescale 1ns / 1ps

package rmt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int STORE_COUNT   = 8;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int RANK_W = IDX_W;

    localparam int MODE_W      = 2;
    localparam int STORE_W     = 3;
    localparam int PID_W       = 6;
    localparam int PAGE_W      = 20;
    localparam int COUNT_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int MASK_W      = 8;
    localparam int STORE_NUM   = 2 ** STORE_W;
    // wide enough to hold STORE_COUNT itself
    localparam int STORE_CMP_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAN  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOMATCH = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

endpackage

/* rtl/core/range_mapping_table.sv */
// range mapping table: sequenced scan over the entry table
`timescale 1ns / 1ps

// A transaction first takes the request into registers, then a single
// compare unit walks the TABLE_ENTRIES entries in slot order, one entry per
// cycle, and last the table is updated and the result register loaded.
// s_ready is high only while no request is in progress; a result waiting
// on m_ready does not block a new request, but the next result is held
// back until the previous one is taken. Find and delete pick the matching
// entry of the lowest store, newest first; clean drops every entry of the
// pid and reports the stores left empty.
module range_mapping_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rmt_pkg::MODE_W-1:0]   s_mode,
    input  logic [rmt_pkg::STORE_W-1:0]  s_store_id,
    input  logic [rmt_pkg::PID_W-1:0]    s_pid,
    input  logic [rmt_pkg::PAGE_W-1:0]   s_vpage,
    input  logic [rmt_pkg::COUNT_W-1:0]  s_page_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rmt_pkg::STATUS_W-1:0] m_status,
    output logic [rmt_pkg::STORE_W-1:0]  m_found_store,
    output logic [rmt_pkg::PAGE_W-1:0]   m_found_base,
    output logic [rmt_pkg::COUNT_W-1:0]  m_found_count,
    output logic [rmt_pkg::MASK_W-1:0]   m_empty_store_mask
);
    import rmt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // entry table
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]        rank_reg  [TABLE_ENTRIES];
    logic [RANK_W-1:0]        rank_next [TABLE_ENTRIES];
    logic [STORE_W-1:0]       store_mem [TABLE_ENTRIES];
    logic [PID_W-1:0]         owner_mem [TABLE_ENTRIES];
    logic [PAGE_W-1:0]        base_mem  [TABLE_ENTRIES];
    logic [COUNT_W-1:0]       len_mem   [TABLE_ENTRIES];
    logic                     wr_en;

    // request held for the whole transaction
    mode_t               mode_reg, mode_next;
    logic [STORE_W-1:0]  store_reg, store_next;
    logic [PID_W-1:0]    pid_reg, pid_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // scan state
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 free_hit_reg, free_hit_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 best_hit_reg, best_hit_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [STORE_W-1:0]   best_store_reg, best_store_next;
    logic [RANK_W-1:0]    best_rank_reg, best_rank_next;
    logic [PAGE_W-1:0]    best_base_reg, best_base_next;
    logic [COUNT_W-1:0]   best_len_reg, best_len_next;
    logic [STORE_NUM-1:0] used_reg, used_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [STORE_W-1:0]  m_store_reg, m_store_next;
    logic [PAGE_W-1:0]   m_base_reg, m_base_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    logic [MASK_W-1:0]   m_mask_reg, m_mask_next;

    // shared compare unit on the entry under the scan index
    logic                cur_valid;
    logic [STORE_W-1:0]  cur_store;
    logic [RANK_W-1:0]   cur_rank;
    logic [PAGE_W-1:0]   cur_base;
    logic [COUNT_W-1:0]  cur_len;
    logic                owner_hit;
    logic [PAGE_W:0]     range_end;
    logic                in_range;
    logic                better;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_store = store_mem[idx_reg];
    assign cur_rank  = rank_reg[idx_reg];
    assign cur_base  = base_mem[idx_reg];
    assign cur_len   = len_mem[idx_reg];

    assign owner_hit = cur_valid && (owner_mem[idx_reg] == pid_reg);
    assign range_end = (PAGE_W+1)'(cur_base) + (PAGE_W+1)'(cur_len);
    assign in_range  = (page_reg >= cur_base) && ((PAGE_W+1)'(page_reg) < range_end);
    assign better    = !best_hit_reg || (cur_store < best_store_reg) ||
                       ((cur_store == best_store_reg) && (cur_rank < best_rank_reg));

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        wr_en           = 1'b0;
        mode_next       = mode_reg;
        store_next      = store_reg;
        pid_next        = pid_reg;
        page_next       = page_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        free_hit_next   = free_hit_reg;
        free_idx_next   = free_idx_reg;
        best_hit_next   = best_hit_reg;
        best_idx_next   = best_idx_reg;
        best_store_next = best_store_reg;
        best_rank_next  = best_rank_reg;
        best_base_next  = best_base_reg;
        best_len_next   = best_len_reg;
        used_next       = used_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_store_next    = m_store_reg;
        m_base_next     = m_base_reg;
        m_count_next    = m_count_reg;
        m_mask_next     = m_mask_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next     = mode_t'(s_mode);
                    store_next    = s_store_id;
                    pid_next      = s_pid;
                    page_next     = s_vpage;
                    count_next    = s_page_count;
                    idx_next      = '0;
                    free_hit_next = 1'b0;
                    best_hit_next = 1'b0;
                    used_next     = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN: begin
                case (mode_reg) inside
                    MODE_ADD: begin
                        if (!cur_valid && !free_hit_reg) begin
                            free_hit_next = 1'b1;
                            free_idx_next = idx_reg;
                        end
                    end
                    MODE_FIND, MODE_DELETE: begin
                        if (owner_hit && in_range && better) begin
                            best_hit_next   = 1'b1;
                            best_idx_next   = idx_reg;
                            best_store_next = cur_store;
                            best_rank_next  = cur_rank;
                            best_base_next  = cur_base;
                            best_len_next   = cur_len;
                        end
                    end
                    default: begin
                        // clean: drop this entry and close the gap in the age ranks
                        if (owner_hit) begin
                            valid_next[idx_reg] = 1'b0;
                            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                                if (valid_reg[k] && (rank_reg[k] > cur_rank)) begin
                                    rank_next[k] = rank_reg[k] - RANK_W'(1);
                                end
                            end
                        end else if (cur_valid) begin
                            used_next[cur_store] = 1'b1;
                        end
                    end
                endcase
                if (idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_OK;
                    m_store_next  = '0;
                    m_base_next   = '0;
                    m_count_next  = '0;
                    m_mask_next   = '0;
                    state_next    = ST_IDLE;
                    case (mode_reg)
                        MODE_ADD: begin
                            if (STORE_CMP_W'(store_reg) >= STORE_CMP_W'(STORE_COUNT)) begin
                                m_status_next = STATUS_NOMATCH;
                            end else if (!free_hit_reg) begin
                                m_status_next = STATUS_FULL;
                            end else begin
                                wr_en = 1'b1;
                                for (int k = 0; k < TABLE_ENTRIES; k++) begin
                                    if (valid_reg[k]) begin
                                        rank_next[k] = rank_reg[k] + RANK_W'(1);
                                    end
                                end
                                valid_next[free_idx_reg] = 1'b1;
                                rank_next[free_idx_reg]  = '0;
                            end
                        end
                        MODE_FIND: begin
                            if (best_hit_reg) begin
                                m_store_next = best_store_reg;
                                m_base_next  = best_base_reg;
                                m_count_next = best_len_reg;
                            end else begin
                                m_status_next = STATUS_NOMATCH;
                            end
                        end
                        MODE_DELETE: begin
                            if (best_hit_reg) begin
                                valid_next[best_idx_reg] = 1'b0;
                                for (int k = 0; k < TABLE_ENTRIES; k++) begin
                                    if (valid_reg[k] && (rank_reg[k] > best_rank_reg)) begin
                                        rank_next[k] = rank_reg[k] - RANK_W'(1);
                                    end
                                end
                            end else begin
                                m_status_next = STATUS_NOMATCH;
                            end
                        end
                        default: begin
                            for (int i = 0; i < MASK_W; i++) begin
                                if (i < STORE_COUNT && i < STORE_NUM) begin
                                    m_mask_next[i] = !used_reg[i];
                                end
                            end
                        end
                    endcase
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_status_reg <= STATUS_OK;
            m_store_reg  <= '0;
            m_base_reg   <= '0;
            m_count_reg  <= '0;
            m_mask_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
            m_status_reg <= m_status_next;
            m_store_reg  <= m_store_next;
            m_base_reg   <= m_base_next;
            m_count_reg  <= m_count_next;
            m_mask_reg   <= m_mask_next;
        end
    end

    // datapath registers and entry storage
    always_ff @(posedge aclk) begin
        rank_reg       <= rank_next;
        mode_reg       <= mode_next;
        store_reg      <= store_next;
        pid_reg        <= pid_next;
        page_reg       <= page_next;
        count_reg      <= count_next;
        idx_reg        <= idx_next;
        free_hit_reg   <= free_hit_next;
        free_idx_reg   <= free_idx_next;
        best_hit_reg   <= best_hit_next;
        best_idx_reg   <= best_idx_next;
        best_store_reg <= best_store_next;
        best_rank_reg  <= best_rank_next;
        best_base_reg  <= best_base_next;
        best_len_reg   <= best_len_next;
        used_reg       <= used_next;
        if (wr_en) begin
            store_mem[free_idx_reg] <= store_reg;
            owner_mem[free_idx_reg] <= pid_reg;
            base_mem[free_idx_reg]  <= page_reg;
            len_mem[free_idx_reg]   <= count_reg;
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_found_store      = m_store_reg;
    assign m_found_base       = m_base_reg;
    assign m_found_count      = m_count_reg;
    assign m_empty_store_mask = m_mask_reg;

endmodule

/* rtl/core/rmt_checker.sv */
// port-level checks for the range mapping table, bound to the top level
`timescale 1ns / 1ps
`include "range_mapping_table_defines.svh"

module rmt_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [rmt_pkg::STATUS_W-1:0] m_status,
    input logic [rmt_pkg::STORE_W-1:0]  m_found_store,
    input logic [rmt_pkg::PAGE_W-1:0]   m_found_base,
    input logic [rmt_pkg::COUNT_W-1:0]  m_found_count,
    input logic [rmt_pkg::MASK_W-1:0]   m_empty_store_mask
);
    import rmt_pkg::*;

    // a stalled result keeps its status, base and empty store mask
    `RMT_ASSERT_NEXT(a_result_hold, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_found_base) && $stable(m_empty_store_mask),
        "result changed while stalled")

    // a transaction keeps the block busy for its scan
    `RMT_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "request taken while a scan runs")

    // a failed operation reports no entry fields
    `RMT_ASSERT_NOW(a_fail_no_fields, m_valid && (m_status != STATUS_OK),
        (m_found_store == '0) && (m_found_base == '0) && (m_found_count == '0) &&
        (m_empty_store_mask == '0),
        "fields set on failure")

    // an empty store mask comes only from a clean, which never fails or finds
    `RMT_ASSERT_NOW(a_mask_only_clean, m_valid && (m_empty_store_mask != '0),
        (m_status == STATUS_OK) && (m_found_count == '0) && (m_found_base == '0),
        "mask reported with find fields")

endmodule

bind range_mapping_table rmt_checker u_rmt_checker (.*);
